/* hdl/kcp_pkg.sv */
// ----------------------------------------------------------------------------
// kcp_pkg
// Shared types, key codes and helpers for the keystroke calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package kcp_pkg;

  // operand magnitude width, signed value width, mul/div register width
  localparam int MAG_W = 30;
  localparam int VAL_W = 31;
  localparam int MD_W  = 2 * MAG_W;
  localparam int CNT_W = 6;
  localparam int LIM_W = 17;
  localparam int NV_W  = 36;

  localparam logic [MAG_W-1:0] ENTRY_MAX = 30'd999999999;
  localparam logic [LIM_W-1:0] LIMIT_RST = 17'd10000;

  // key codes
  localparam logic [4:0] KEY_9      = 5'd9;
  localparam logic [4:0] KEY_POINT  = 5'd10;
  localparam logic [4:0] KEY_EQUALS = 5'd11;
  localparam logic [4:0] KEY_PLUS   = 5'd12;
  localparam logic [4:0] KEY_MINUS  = 5'd13;
  localparam logic [4:0] KEY_TIMES  = 5'd14;
  localparam logic [4:0] KEY_DIVIDE = 5'd15;
  localparam logic [4:0] KEY_CLEAR  = 5'd19;

  // display kinds
  localparam logic [1:0] KIND_ENTRY  = 2'd0;
  localparam logic [1:0] KIND_RESULT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_MD, ST_POST, ST_OP2, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    PH_FIRST, PH_ADD, PH_MUL, PH_ADDMUL, PH_ERROR
  } main_phase_t;

  typedef enum logic [1:0] {
    EP_START, EP_SIGN, EP_INT, EP_FRAC
  } entry_phase_t;

  typedef enum logic [1:0] {
    MD_IDLE, MD_MUL, MD_DIV, MD_DONE
  } md_stage_t;

  typedef struct packed {
    logic       clear;
    logic       ev_int;
    logic       ev_frac;
    logic       set_sign;
    logic       sign_neg;
    logic       acc_from_entry;
    logic       pend_from_entry;
    logic       md_start;
    logic       md_is_div;
    logic       md_use_pend;
    logic       md_write;
    logic       sum_write;
    logic       sum_minus;
    logic       eq_finish;
    logic       new_operand;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_accepted;
    logic [3:0] digit;
    logic [2:0] frac_pos;
  } cmd_t;

  typedef struct packed {
    logic int_ovf;
    logic frac_ovf;
    logic entry_zero;
    logic md_done;
    logic md_fail;
    logic sum_fail;
    logic acc_fail;
    logic out_busy;
  } status_t;

  // power of ten for small exponents
  function automatic logic [19:0] pow10(input logic [2:0] n);
    logic [19:0] r;
    r = 20'd1;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < n) r = 20'(r * 20'd10);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/kcp_datapath.sv */
// ----------------------------------------------------------------------------
// kcp_datapath
// Operand, accumulator and limit registers, shift-add multiplier and
// restoring divider, and the result register of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module kcp_datapath #(
  parameter int FRACTION_DIGITS = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire kcp_pkg::cmd_t            cmd,
  output kcp_pkg::status_t              status,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [kcp_pkg::LIM_W-1:0]     cfg_result_limit,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [kcp_pkg::VAL_W-1:0] out_shown_value,
  output logic [1:0]                    out_shown_kind,
  output logic                          out_key_accepted
);

  localparam int MAG_W = kcp_pkg::MAG_W;
  localparam int VAL_W = kcp_pkg::VAL_W;
  localparam int MD_W  = kcp_pkg::MD_W;
  localparam int NV_W  = kcp_pkg::NV_W;
  localparam int BW    = kcp_pkg::LIM_W + 20;
  localparam logic [19:0] SCALE = kcp_pkg::pow10(3'(FRACTION_DIGITS));
  localparam logic [BW-1:0] RST_WIDE = BW'(kcp_pkg::LIMIT_RST) * BW'(SCALE);
  localparam logic [MAG_W-1:0] BOUND_RST =
    (RST_WIDE > BW'(kcp_pkg::ENTRY_MAX)) ? kcp_pkg::ENTRY_MAX : RST_WIDE[MAG_W-1:0];

  logic [kcp_pkg::LIM_W-1:0] limit_r;
  logic [MAG_W-1:0]          bound_r, bound_nxt;
  logic signed [VAL_W-1:0]   acc_r, pend_r;
  logic [MAG_W-1:0]          ev_r;
  logic                      neg_r;
  kcp_pkg::md_stage_t        md_r;
  logic [kcp_pkg::CNT_W-1:0] cnt_r;
  logic [MD_W-1:0]           prod_r, mcand_r;
  logic [MAG_W-1:0]          mplier_r, div_r, rem_r;
  logic                      md_neg_r;
  logic                      out_valid_r;
  logic signed [VAL_W-1:0]   out_value_r;
  logic [1:0]                out_kind_r;
  logic                      out_acc_r;

  logic [BW-1:0]           bound_wide;
  logic signed [VAL_W-1:0] entry_s, md_res, md_x, show_v;
  logic [VAL_W-1:0]        x_mag, acc_mag;
  logic [NV_W-1:0]         nv_int, nv_frac;
  logic [2:0]              frac_exp;
  logic [MAG_W:0]          div_t;
  logic                    div_ge;
  logic signed [VAL_W:0]   sum_s;
  logic [VAL_W:0]          sum_mag;

  assign cfg_ready = 1'b1;

  // result bound from the limit register
  always_comb begin
    bound_wide = BW'(limit_r) * BW'(SCALE);
    bound_nxt  = (bound_wide > BW'(kcp_pkg::ENTRY_MAX)) ? kcp_pkg::ENTRY_MAX
                                                        : bound_wide[MAG_W-1:0];
  end

  // digit entry and operand arithmetic
  always_comb begin
    entry_s  = neg_r ? -$signed({1'b0, ev_r}) : $signed({1'b0, ev_r});
    frac_exp = 3'(FRACTION_DIGITS - 1) - cmd.frac_pos;
    nv_int   = NV_W'(ev_r) * NV_W'(10) + NV_W'(cmd.digit) * NV_W'(SCALE);
    nv_frac  = NV_W'(ev_r) + NV_W'(cmd.digit) * NV_W'(kcp_pkg::pow10(frac_exp));
    md_x     = cmd.md_use_pend ? pend_r : acc_r;
    x_mag    = md_x[VAL_W-1] ? VAL_W'(-md_x) : VAL_W'(md_x);
    acc_mag  = acc_r[VAL_W-1] ? VAL_W'(-acc_r) : VAL_W'(acc_r);
    sum_s    = cmd.sum_minus ? (VAL_W+1)'(acc_r) - (VAL_W+1)'(pend_r)
                             : (VAL_W+1)'(acc_r) + (VAL_W+1)'(pend_r);
    sum_mag  = sum_s[VAL_W] ? (VAL_W+1)'(-sum_s) : (VAL_W+1)'(sum_s);
    md_res   = md_neg_r ? -$signed({1'b0, prod_r[MAG_W-1:0]})
                        : $signed({1'b0, prod_r[MAG_W-1:0]});
    div_t    = {rem_r, prod_r[MD_W-1]};
    div_ge   = div_t >= {1'b0, div_r};
    case (cmd.out_kind)
      kcp_pkg::KIND_ERROR:  show_v = '0;
      kcp_pkg::KIND_RESULT: show_v = acc_r;
      default:              show_v = entry_s;
    endcase
  end

  // status back to the controller
  always_comb begin
    status.int_ovf    = nv_int > NV_W'(kcp_pkg::ENTRY_MAX);
    status.frac_ovf   = nv_frac > NV_W'(kcp_pkg::ENTRY_MAX);
    status.entry_zero = ev_r == '0;
    status.md_done    = md_r == kcp_pkg::MD_DONE;
    status.md_fail    = (prod_r[MD_W-1:MAG_W] != '0) || (prod_r[MAG_W-1:0] > bound_r);
    status.sum_fail   = sum_mag > (VAL_W+1)'(bound_r);
    status.acc_fail   = acc_mag > VAL_W'(bound_r);
    status.out_busy   = out_valid_r && !out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= kcp_pkg::LIMIT_RST;
      bound_r     <= BOUND_RST;
      md_r        <= kcp_pkg::MD_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) limit_r <= cfg_result_limit;
      bound_r <= bound_nxt;
      // drop a taken item, load a new one
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      // mul/div sequencing
      if (cmd.clear || cmd.md_write) begin
        md_r <= kcp_pkg::MD_IDLE;
      end else if (cmd.md_start) begin
        md_r  <= kcp_pkg::MD_MUL;
        cnt_r <= '0;
      end else begin
        case (md_r)
          kcp_pkg::MD_MUL: begin
            if (cnt_r == kcp_pkg::CNT_W'(MAG_W - 1)) begin
              md_r  <= kcp_pkg::MD_DIV;
              cnt_r <= '0;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          kcp_pkg::MD_DIV: begin
            if (cnt_r == kcp_pkg::CNT_W'(MD_W - 1)) md_r <= kcp_pkg::MD_DONE;
            else cnt_r <= cnt_r + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
      ev_r   <= '0;
      neg_r  <= 1'b0;
    end else if (cmd.clear) begin
      acc_r  <= '0;
      pend_r <= '0;
      ev_r   <= '0;
      neg_r  <= 1'b0;
    end else begin
      if (cmd.ev_int)   ev_r <= nv_int[MAG_W-1:0];
      if (cmd.ev_frac)  ev_r <= nv_frac[MAG_W-1:0];
      if (cmd.set_sign) neg_r <= cmd.sign_neg;
      if (cmd.acc_from_entry)  acc_r  <= entry_s;
      if (cmd.pend_from_entry) pend_r <= entry_s;
      if (cmd.md_write) begin
        if (cmd.md_use_pend) pend_r <= md_res;
        else acc_r <= md_res;
      end
      if (cmd.sum_write) begin
        acc_r  <= VAL_W'(sum_s);
        pend_r <= '0;
      end
      if (cmd.eq_finish) pend_r <= '0;
      if (cmd.new_operand || cmd.eq_finish) begin
        ev_r  <= '0;
        neg_r <= 1'b0;
      end
    end
  end

  // shift-add multiply, then restoring divide on the product
  always_ff @(posedge clk) begin
    if (cmd.md_start) begin
      prod_r   <= '0;
      mcand_r  <= MD_W'(x_mag);
      mplier_r <= cmd.md_is_div ? MAG_W'(SCALE) : ev_r;
      div_r    <= cmd.md_is_div ? ev_r : MAG_W'(SCALE);
      md_neg_r <= md_x[VAL_W-1] ^ (neg_r && ev_r != '0);
      rem_r    <= '0;
    end else if (md_r == kcp_pkg::MD_MUL) begin
      if (mplier_r[0]) prod_r <= prod_r + mcand_r;
      mcand_r  <= {mcand_r[MD_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[MAG_W-1:1]};
    end else if (md_r == kcp_pkg::MD_DIV) begin
      rem_r  <= div_ge ? MAG_W'(div_t - {1'b0, div_r}) : div_t[MAG_W-1:0];
      prod_r <= {prod_r[MD_W-2:0], div_ge};
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= show_v;
      out_kind_r  <= cmd.out_kind;
      out_acc_r   <= cmd.out_accepted;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_shown_value  = out_value_r;
  assign out_shown_kind   = out_kind_r;
  assign out_key_accepted = out_acc_r;

endmodule

`default_nettype wire

/* hdl/kcp_ctrl.sv */
// ----------------------------------------------------------------------------
// kcp_ctrl
// Key decoder and sequencer: calculator phases, entry phase, fraction count
// and operator flags; drives the datapath by commands.
// ----------------------------------------------------------------------------
`default_nettype none

module kcp_ctrl #(
  parameter int FRACTION_DIGITS = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [4:0]            in_key_code,
  input  wire kcp_pkg::status_t status,
  output kcp_pkg::cmd_t         cmd
);

  kcp_pkg::ctrl_state_t  state_r, state_nxt;
  kcp_pkg::main_phase_t  phase_r, phase_nxt;
  kcp_pkg::entry_phase_t ep_r, ep_nxt;
  logic [4:0] key_r, key_nxt;
  logic [2:0] fd_r, fd_nxt;
  logic       add_minus_r, add_minus_nxt;
  logic       mdiv_r, mdiv_nxt;
  logic       rs_r, rs_nxt;
  logic       acc_flag_r, acc_flag_nxt;
  logic       clr, to_err, is_op;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kcp_pkg::ST_IDLE;
      phase_r     <= kcp_pkg::PH_FIRST;
      ep_r        <= kcp_pkg::EP_START;
      key_r       <= '0;
      fd_r        <= '0;
      add_minus_r <= 1'b0;
      mdiv_r      <= 1'b0;
      rs_r        <= 1'b0;
      acc_flag_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      ep_r        <= ep_nxt;
      key_r       <= key_nxt;
      fd_r        <= fd_nxt;
      add_minus_r <= add_minus_nxt;
      mdiv_r      <= mdiv_nxt;
      rs_r        <= rs_nxt;
      acc_flag_r  <= acc_flag_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    ep_nxt        = ep_r;
    key_nxt       = key_r;
    fd_nxt        = fd_r;
    add_minus_nxt = add_minus_r;
    mdiv_nxt      = mdiv_r;
    rs_nxt        = rs_r;
    acc_flag_nxt  = acc_flag_r;
    clr           = 1'b0;
    to_err        = 1'b0;
    in_ready      = 1'b0;
    is_op         = (key_r == kcp_pkg::KEY_PLUS) || (key_r == kcp_pkg::KEY_MINUS);
    cmd             = '0;
    cmd.digit       = key_r[3:0];
    cmd.frac_pos    = fd_r;
    cmd.md_is_div   = mdiv_r;
    cmd.md_use_pend = phase_r == kcp_pkg::PH_ADDMUL;
    cmd.sum_minus   = add_minus_r;

    case (state_r)
      kcp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt   = in_key_code;
          // a digit, point or operator key after a result starts from cleared state
          if (rs_r && in_key_code <= kcp_pkg::KEY_DIVIDE) clr = 1'b1;
          state_nxt = kcp_pkg::ST_DECIDE;
        end
      end

      kcp_pkg::ST_DECIDE: begin
        state_nxt    = kcp_pkg::ST_EMIT;
        acc_flag_nxt = 1'b1;
        if (phase_r == kcp_pkg::PH_ERROR) begin
          if (key_r == kcp_pkg::KEY_CLEAR) clr = 1'b1;
          else acc_flag_nxt = 1'b0;
        end else if (key_r == kcp_pkg::KEY_CLEAR) begin
          clr = 1'b1;
        end else if (key_r > kcp_pkg::KEY_DIVIDE) begin
          acc_flag_nxt = 1'b0;
        end else if (key_r <= kcp_pkg::KEY_9) begin
          if (ep_r == kcp_pkg::EP_FRAC) begin
            if (fd_r >= 3'(FRACTION_DIGITS) || status.frac_ovf) begin
              acc_flag_nxt = 1'b0;
            end else begin
              cmd.ev_frac = 1'b1;
              fd_nxt      = fd_r + 1'b1;
            end
          end else if (status.int_ovf) begin
            acc_flag_nxt = 1'b0;
          end else begin
            cmd.ev_int = 1'b1;
            ep_nxt     = kcp_pkg::EP_INT;
          end
        end else if (key_r == kcp_pkg::KEY_POINT) begin
          if (ep_r == kcp_pkg::EP_FRAC) acc_flag_nxt = 1'b0;
          else ep_nxt = kcp_pkg::EP_FRAC;
        end else if (ep_r == kcp_pkg::EP_START && is_op) begin
          cmd.set_sign = 1'b1;
          cmd.sign_neg = key_r == kcp_pkg::KEY_MINUS;
          ep_nxt       = kcp_pkg::EP_SIGN;
        end else if (ep_r == kcp_pkg::EP_SIGN) begin
          acc_flag_nxt = 1'b0;
        end else if (ep_r == kcp_pkg::EP_START && key_r != kcp_pkg::KEY_EQUALS) begin
          acc_flag_nxt = 1'b0;
        end else begin
          // operand finished
          case (phase_r)
            kcp_pkg::PH_FIRST: begin
              cmd.acc_from_entry = 1'b1;
              state_nxt          = kcp_pkg::ST_POST;
            end
            kcp_pkg::PH_ADD: begin
              cmd.pend_from_entry = 1'b1;
              state_nxt           = kcp_pkg::ST_POST;
            end
            default: begin
              if (mdiv_r && status.entry_zero) begin
                to_err = 1'b1;
              end else begin
                cmd.md_start = 1'b1;
                state_nxt    = kcp_pkg::ST_MD;
              end
            end
          endcase
        end
      end

      kcp_pkg::ST_MD: begin
        if (status.md_done) begin
          if (status.md_fail) begin
            to_err = 1'b1;
          end else begin
            cmd.md_write = 1'b1;
            state_nxt    = kcp_pkg::ST_POST;
          end
        end
      end

      kcp_pkg::ST_POST: begin
        if (key_r == kcp_pkg::KEY_TIMES || key_r == kcp_pkg::KEY_DIVIDE) begin
          mdiv_nxt  = key_r == kcp_pkg::KEY_DIVIDE;
          phase_nxt = (phase_r == kcp_pkg::PH_FIRST || phase_r == kcp_pkg::PH_MUL)
                      ? kcp_pkg::PH_MUL : kcp_pkg::PH_ADDMUL;
          cmd.new_operand = 1'b1;
          ep_nxt          = kcp_pkg::EP_START;
          fd_nxt          = '0;
          acc_flag_nxt    = 1'b1;
          state_nxt       = kcp_pkg::ST_EMIT;
        end else if (phase_r == kcp_pkg::PH_ADD || phase_r == kcp_pkg::PH_ADDMUL) begin
          if (status.sum_fail) begin
            to_err = 1'b1;
          end else begin
            cmd.sum_write = 1'b1;
            state_nxt     = kcp_pkg::ST_OP2;
          end
        end else begin
          state_nxt = kcp_pkg::ST_OP2;
        end
      end

      kcp_pkg::ST_OP2: begin
        acc_flag_nxt = 1'b1;
        state_nxt    = kcp_pkg::ST_EMIT;
        if (is_op) begin
          add_minus_nxt   = key_r == kcp_pkg::KEY_MINUS;
          phase_nxt       = kcp_pkg::PH_ADD;
          cmd.new_operand = 1'b1;
          ep_nxt          = kcp_pkg::EP_START;
          fd_nxt          = '0;
        end else if (status.acc_fail) begin
          to_err = 1'b1;
        end else begin
          // equals: keep the accumulator, clear the rest
          cmd.eq_finish = 1'b1;
          phase_nxt     = kcp_pkg::PH_FIRST;
          ep_nxt        = kcp_pkg::EP_START;
          fd_nxt        = '0;
          add_minus_nxt = 1'b0;
          mdiv_nxt      = 1'b0;
          rs_nxt        = 1'b1;
        end
      end

      kcp_pkg::ST_EMIT: begin
        // hold while the previous item is still waiting
        if (!status.out_busy) begin
          cmd.out_load     = 1'b1;
          cmd.out_accepted = acc_flag_r;
          if (phase_r == kcp_pkg::PH_ERROR) cmd.out_kind = kcp_pkg::KIND_ERROR;
          else if (rs_r) cmd.out_kind = kcp_pkg::KIND_RESULT;
          else cmd.out_kind = kcp_pkg::KIND_ENTRY;
          state_nxt = kcp_pkg::ST_IDLE;
        end
      end

      default: state_nxt = kcp_pkg::ST_IDLE;
    endcase

    // clear all calculation state, and enter error where needed
    if (clr || to_err) begin
      cmd.clear     = 1'b1;
      phase_nxt     = kcp_pkg::PH_FIRST;
      ep_nxt        = kcp_pkg::EP_START;
      fd_nxt        = '0;
      add_minus_nxt = 1'b0;
      mdiv_nxt      = 1'b0;
      rs_nxt        = 1'b0;
    end
    if (to_err) begin
      phase_nxt    = kcp_pkg::PH_ERROR;
      acc_flag_nxt = 1'b1;
      state_nxt    = kcp_pkg::ST_EMIT;
    end
  end

endmodule

`default_nettype wire

/* hdl/keystroke_calculator_precedence_unit.sv */
// ----------------------------------------------------------------------------
// keystroke_calculator_precedence_unit
// Four-function decimal calculator with multiply/divide precedence, fed one
// key code per item; signed fixed-point values scaled by 10^FRACTION_DIGITS.
//
// Usage:
//   in_*  : one key code per item (valid/ready). Every key gives exactly one
//           item on out_*: the value shown, its kind (entry, result, error)
//           and whether the key was accepted.
//   cfg_* : writes result_limit; write only while no key is in flight.
//   Keys pass decide, then emit: digit, point, sign, clear and refused
//   keys directly; times or divide closing a plain operand by way of post;
//   add, subtract and equals by way of post and op2; a key that completes
//   a multiply or divide runs the shared mul/div unit first (30 shift-add
//   steps, then 60 restoring divide steps). One key is worked on at a time;
//   the next is taken once the previous result is loaded.
//   Reset: synchronous, active low; all calculation state cleared, limit
//   back to 10000, no output pending.
//   Stall: a held output keeps its item; a following key is still taken and
//   processed, then waits with in_ready low until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module keystroke_calculator_precedence_unit #(
  parameter int FRACTION_DIGITS = 4
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [4:0]                     in_key_code,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [kcp_pkg::VAL_W-1:0] out_shown_value,
  output logic [1:0]                     out_shown_kind,
  output logic                           out_key_accepted,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [kcp_pkg::LIM_W-1:0]      cfg_result_limit
);

  kcp_pkg::cmd_t    cmd;
  kcp_pkg::status_t status;

  kcp_ctrl #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_key_code(in_key_code),
    .status     (status),
    .cmd        (cmd)
  );

  kcp_datapath #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_result_limit(cfg_result_limit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_shown_value (out_shown_value),
    .out_shown_kind  (out_shown_kind),
    .out_key_accepted(out_key_accepted)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Keystroke calculator testbench
// Drives key items with random gaps and output stalls, predicts every shown
// value, kind and accept flag, and checks each output item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam longint SCALE_F = 10000;
  localparam longint ENTRY_LIM = 999999999;
  localparam int FRAC_MAX = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [kcp_pkg::VAL_W-1:0] value;
    logic [1:0] kind;
    logic accepted;
  } display_t;

  // calculator shadow state and expected display queue
  class calc_scoreboard;
    longint limit_units;
    kcp_pkg::main_phase_t phase;
    kcp_pkg::entry_phase_t entry;
    longint acc, pend, ev;
    bit neg, minus_op, div_op, shown_res, bad;
    int fd;
    display_t pending_displays[$];
    int errors;

    function new();
      limit_units = kcp_pkg::LIMIT_RST;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      phase = kcp_pkg::PH_FIRST; entry = kcp_pkg::EP_START;
      acc = 0; pend = 0; ev = 0; fd = 0;
      neg = 0; minus_op = 0; div_op = 0; shown_res = 0; bad = 0;
    endfunction

    function longint ceiling();
      longint b;
      b = limit_units * SCALE_F;
      return (b < ENTRY_LIM) ? b : ENTRY_LIM;
    endfunction

    function longint bounded(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      if (m > ceiling()) begin
        bad = 1;
        return 0;
      end
      return v;
    endfunction

    function longint mul_or_div(longint x, longint y, bit dv);
      longint mx, my, r;
      bit ng;
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      ng = (x < 0) != (y < 0);
      if (dv) begin
        if (my == 0) begin
          bad = 1;
          return 0;
        end
        r = (mx * SCALE_F) / my;
      end else begin
        r = (mx * my) / SCALE_F;
      end
      return bounded(ng ? -r : r);
    endfunction

    function void push(longint v, logic [1:0] k, bit a);
      display_t d;
      d.value = kcp_pkg::VAL_W'(v);
      d.kind = k;
      d.accepted = a;
      pending_displays.push_back(d);
    endfunction

    function void show(bit a);
      if (phase == kcp_pkg::PH_ERROR) push(0, kcp_pkg::KIND_ERROR, a);
      else if (shown_res) push(acc, kcp_pkg::KIND_RESULT, a);
      else push(neg ? -ev : ev, kcp_pkg::KIND_ENTRY, a);
    endfunction

    function void fail_state();
      wipe();
      phase = kcp_pkg::PH_ERROR;
      push(0, kcp_pkg::KIND_ERROR, 1);
    endfunction

    // work out the display caused by one accepted key
    function void note_key(logic [4:0] k);
      longint v, nv, p;
      if (phase == kcp_pkg::PH_ERROR) begin
        if (k == kcp_pkg::KEY_CLEAR) begin
          wipe();
          push(0, kcp_pkg::KIND_ENTRY, 1);
        end else push(0, kcp_pkg::KIND_ERROR, 0);
        return;
      end
      if (k == kcp_pkg::KEY_CLEAR) begin
        wipe();
        push(0, kcp_pkg::KIND_ENTRY, 1);
        return;
      end
      if (k > kcp_pkg::KEY_DIVIDE) begin
        show(0);
        return;
      end
      if (shown_res) wipe();
      if (k <= kcp_pkg::KEY_9) begin
        if (entry == kcp_pkg::EP_FRAC) begin
          if (fd >= FRAC_MAX) begin
            show(0);
            return;
          end
          p = 1;
          for (int i = 0; i < FRAC_MAX - fd - 1; i++) p = p * 10;
          nv = ev + k * p;
          if (nv > ENTRY_LIM) begin
            show(0);
            return;
          end
          fd++;
        end else begin
          nv = ev * 10 + k * SCALE_F;
          if (nv > ENTRY_LIM) begin
            show(0);
            return;
          end
          entry = kcp_pkg::EP_INT;
        end
        ev = nv;
        show(1);
        return;
      end
      if (k == kcp_pkg::KEY_POINT) begin
        if (entry == kcp_pkg::EP_FRAC) show(0);
        else begin
          entry = kcp_pkg::EP_FRAC;
          show(1);
        end
        return;
      end
      if (entry == kcp_pkg::EP_START && (k == kcp_pkg::KEY_PLUS || k == kcp_pkg::KEY_MINUS)) begin
        neg = (k == kcp_pkg::KEY_MINUS);
        entry = kcp_pkg::EP_SIGN;
        show(1);
        return;
      end
      if (entry == kcp_pkg::EP_SIGN ||
          (entry == kcp_pkg::EP_START && k != kcp_pkg::KEY_EQUALS)) begin
        show(0);
        return;
      end
      // operand complete: fold it in by precedence
      v = neg ? -ev : ev;
      bad = 0;
      case (phase)
        kcp_pkg::PH_FIRST: acc = v;
        kcp_pkg::PH_ADD: pend = v;
        kcp_pkg::PH_MUL: acc = mul_or_div(acc, v, div_op);
        default: pend = mul_or_div(pend, v, div_op);
      endcase
      if (bad) begin
        fail_state();
        return;
      end
      if (k == kcp_pkg::KEY_TIMES || k == kcp_pkg::KEY_DIVIDE) begin
        div_op = (k == kcp_pkg::KEY_DIVIDE);
        phase = (phase == kcp_pkg::PH_FIRST || phase == kcp_pkg::PH_MUL)
                ? kcp_pkg::PH_MUL : kcp_pkg::PH_ADDMUL;
        entry = kcp_pkg::EP_START; ev = 0; neg = 0; fd = 0;
        push(0, kcp_pkg::KIND_ENTRY, 1);
        return;
      end
      if (phase == kcp_pkg::PH_ADD || phase == kcp_pkg::PH_ADDMUL) begin
        acc = bounded(minus_op ? acc - pend : acc + pend);
        pend = 0;
        if (bad) begin
          fail_state();
          return;
        end
      end
      if (k == kcp_pkg::KEY_PLUS || k == kcp_pkg::KEY_MINUS) begin
        minus_op = (k == kcp_pkg::KEY_MINUS);
        phase = kcp_pkg::PH_ADD;
        entry = kcp_pkg::EP_START; ev = 0; neg = 0; fd = 0;
        push(0, kcp_pkg::KIND_ENTRY, 1);
        return;
      end
      acc = bounded(acc);
      if (bad) begin
        fail_state();
        return;
      end
      v = acc;
      wipe();
      acc = v;
      shown_res = 1;
      push(acc, kcp_pkg::KIND_RESULT, 1);
    endfunction

    function void check_display(logic signed [kcp_pkg::VAL_W-1:0] v, logic [1:0] k,
                                logic a);
      display_t e;
      if (pending_displays.size() == 0) begin
        $error("unexpected output item value=%0d kind=%0d", v, k);
        errors++;
        return;
      end
      e = pending_displays.pop_front();
      if (v !== e.value) begin
        $error("shown_value expected %0d actual %0d", e.value, v);
        errors++;
      end
      if (k !== e.kind) begin
        $error("shown_kind expected %0d actual %0d", e.kind, k);
        errors++;
      end
      if (a !== e.accepted) begin
        $error("key_accepted expected %0d actual %0d", e.accepted, a);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [4:0] in_key_code;
  logic out_valid, out_ready;
  logic signed [kcp_pkg::VAL_W-1:0] out_shown_value;
  logic [1:0] out_shown_kind;
  logic out_key_accepted;
  logic cfg_valid, cfg_ready;
  logic [kcp_pkg::LIM_W-1:0] cfg_result_limit;

  calc_scoreboard calc_sb;
  bit keys_done;
  int idle_cycles;

  keystroke_calculator_precedence_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_key_code(in_key_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_shown_value(out_shown_value), .out_shown_kind(out_shown_kind),
    .out_key_accepted(out_key_accepted),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_result_limit(cfg_result_limit)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // send one key item after a random gap; valid stays up for a back-to-back key
  task automatic press(logic [4:0] k);
    int gap;
    gap = $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_key_code <= k;
    do @(posedge clk); while (!in_ready);
    calc_sb.note_key(k);
    @(negedge clk);
  endtask

  task automatic press_number(int ip, int fr, bit sign);
    if (sign) press($urandom_range(0, 1) ? kcp_pkg::KEY_MINUS : kcp_pkg::KEY_PLUS);
    for (int i = 0; i < ip; i++) press(5'($urandom_range(0, 9)));
    if (fr > 0) begin
      press(kcp_pkg::KEY_POINT);
      for (int i = 0; i < fr; i++) press(5'($urandom_range(0, 9)));
    end
  endtask

  // write the limit once every expected display has come back
  task automatic set_limit(logic [kcp_pkg::LIM_W-1:0] lim);
    in_valid <= 0;
    while (calc_sb.pending_displays.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    cfg_valid <= 1;
    cfg_result_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    calc_sb.limit_units = lim;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_expressions(int n);
    logic [4:0] ops[4];
    int r;
    ops = '{kcp_pkg::KEY_PLUS, kcp_pkg::KEY_MINUS, kcp_pkg::KEY_TIMES, kcp_pkg::KEY_DIVIDE};
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        for (int j = 0; j <= $urandom_range(0, 3); j++) begin
          press_number($urandom_range(0, 3), $urandom_range(0, 5), $urandom_range(0, 3) == 0);
          press(ops[$urandom_range(0, 3)]);
        end
        press_number($urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 3) == 0);
        press($urandom_range(0, 5) == 0 ? ops[$urandom_range(0, 3)] : kcp_pkg::KEY_EQUALS);
      end else if (r < 9) begin
        press(5'($urandom_range(0, 31)));
      end else begin
        press(kcp_pkg::KEY_CLEAR);
      end
    end
  endtask

  // stimulus
  initial begin
    calc_sb = new();
    rst_n = 0; in_valid = 0; in_key_code = 0; out_ready = 0;
    cfg_valid = 0; cfg_result_limit = 0; keys_done = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: operators, refusals, divide by zero, overflow, ignored codes
    press(kcp_pkg::KEY_TIMES); press(kcp_pkg::KEY_MINUS); press(kcp_pkg::KEY_EQUALS);
    press(5'd7); press(kcp_pkg::KEY_POINT); press(kcp_pkg::KEY_POINT); press(5'd1);
    press(5'd2); press(5'd3); press(5'd4); press(5'd5); press(kcp_pkg::KEY_PLUS);
    press(5'd3); press(kcp_pkg::KEY_TIMES); press(5'd2); press(kcp_pkg::KEY_EQUALS);
    press(5'd16); press(5'd8); press(kcp_pkg::KEY_DIVIDE); press(5'd0);
    press(kcp_pkg::KEY_EQUALS); press(5'd3); press(kcp_pkg::KEY_CLEAR); press(5'd31);
    for (int i = 0; i < 11; i++) press(5'd9);
    press(kcp_pkg::KEY_TIMES); press(5'd9); press(kcp_pkg::KEY_EQUALS);
    press(kcp_pkg::KEY_CLEAR);
    set_limit(17'd1);
    random_expressions(6);
    set_limit(17'd99999);
    random_expressions(6);
    set_limit(17'h1FFFF);
    press(kcp_pkg::KEY_CLEAR);
    set_limit(17'd0);
    random_expressions(4);
    set_limit(kcp_pkg::LIM_W'($urandom_range(1, 50)));
    random_expressions(8);
    set_limit(17'd10000);
    random_expressions(8);
    in_valid <= 0;
    keys_done = 1;
  end

  // output side: random stalls, check at the accepting edge
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      @(negedge clk);
      if (wait_n > 0) begin
        out_ready <= 0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      calc_sb.check_display(out_shown_value, out_shown_kind, out_key_accepted);
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else if (keys_done && calc_sb.pending_displays.size() == 0) begin
        repeat (200) @(posedge clk);
        if (calc_sb.errors == 0 && calc_sb.pending_displays.size() == 0)
          $display("Verification passed");
        else $display("Verification failed");
        $finish;
      end
    end
  end
endmodule

`default_nettype wire

/* files.f */
hdl/kcp_pkg.sv
hdl/kcp_datapath.sv
hdl/kcp_ctrl.sv
hdl/keystroke_calculator_precedence_unit.sv
tb/testbench.sv
